/* rtl/ptl_pkg.sv */
// shared constants, codes and types for the periodic timer list
package ptl_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CMD_W        = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int PERIOD_W     = 16;
  localparam int KIND_W       = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_TICK   = 2'd2;
  localparam cmd_t CMD_CLEAR  = 2'd3;

  localparam kind_t KIND_STATUS = 2'd0;
  localparam kind_t KIND_EXPIRY = 2'd1;

endpackage

/* rtl/ptl_ifs.sv */
// valid/ready channel interfaces for commands and results
interface ptl_in_if;
  import ptl_pkg::*;
  logic                    valid;
  logic                    ready;
  cmd_t                    command;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [PERIOD_W-1:0]     period;
  modport source (output valid, command, slot, period, input ready);
  modport sink   (input valid, command, slot, period, output ready);
endinterface

interface ptl_out_if;
  import ptl_pkg::*;
  logic                    valid;
  logic                    ready;
  kind_t                   kind;
  logic                    ok;
  logic [SLOT_FIELD_W-1:0] fired_slot;
  logic                    last;
  modport source (output valid, kind, ok, fired_slot, last, input ready);
  modport sink   (input valid, kind, ok, fired_slot, last, output ready);
endinterface

/* rtl/ptl_ram.sv */
// generic single write port ram with one registered read port
module ptl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/periodic_timer_list_unit.sv */
// periodic timer list: linked timer slots walked by a small sequencer on each tick
//
//  channel  dir  fields                          transfer when
//  in_ch    in   command, slot, period           valid && ready
//  out_ch   out  kind, ok, fired_slot, last      valid && ready
//
// add passes exec, add2 (skipped on an empty list) and resp; remove exec, rmw and resp;
// clear and a rejected add or remove exec and resp, each plus any wait for the output
// register. a tick passes exec, a walk step per linked timer and flush (back to idle
// from exec on an empty list), set by the single read port of the link and count memories.
// reset is synchronous; only state, linked bits, head, tail, count, held-expiry flag and output valid clear.
// the walk holds when a new expiry meets a held one and a full output register;
// in_ready is high only when idle.
module periodic_timer_list_unit #(
  parameter int TIMER_SLOTS = ptl_pkg::TIMER_SLOTS_DEF,
  parameter int COUNT_WIDTH = ptl_pkg::COUNT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptl_in_if.sink     in_ch,
  ptl_out_if.source  out_ch
);
  import ptl_pkg::*;

  localparam int SLOT_W = $clog2(TIMER_SLOTS);
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_ADD2  = 3'd2;
  localparam logic [2:0] ST_RMW   = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [TIMER_SLOTS-1:0]  linked_r, linked_nxt;
  logic [SLOT_W-1:0]       head_r, head_nxt;
  logic [SLOT_W-1:0]       tail_r, tail_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // payload registers
  cmd_t                    cmd_r;
  logic [SLOT_FIELD_W-1:0] slot_r;
  logic [PERIOD_W-1:0]     period_r;
  logic                    ok_r, ok_nxt;
  logic [SLOT_W-1:0]       t_r, t_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]       pend_slot_r, pend_slot_nxt;
  kind_t                   out_kind_r;
  logic                    out_ok_r;
  logic [SLOT_FIELD_W-1:0] out_fired_r;
  logic                    out_last_r;

  // memory ports
  logic                   nx_we, pv_we, rl_we, rm_we;
  logic [SLOT_W-1:0]      nx_waddr, pv_waddr, rl_waddr, rm_waddr;
  logic [SLOT_W-1:0]      nx_wdata, pv_wdata;
  logic [COUNT_WIDTH-1:0] rl_wdata, rm_wdata;
  logic [SLOT_W-1:0]      rd_addr;
  logic [SLOT_W-1:0]      nx_rdata, pv_rdata;
  logic [COUNT_WIDTH-1:0] rl_rdata, rm_rdata;

  logic                   accept, out_free, push;
  kind_t                  push_kind;
  logic                   push_ok, push_last;
  logic [SLOT_FIELD_W-1:0] push_fired;
  logic [SLOT_W-1:0]      s_idx;
  logic                   s_in_range, s_linked;
  logic [PERIOD_W-1:0]    per_nz;
  logic [31:0]            per_wide;
  logic [COUNT_WIDTH-1:0] per_sat;
  logic [COUNT_WIDTH-1:0] dec;
  logic                   fire, go;

  ptl_ram #(.WIDTH(SLOT_W), .DEPTH(TIMER_SLOTS)) u_next_ram (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata), .raddr(rd_addr), .rdata(nx_rdata)
  );
  ptl_ram #(.WIDTH(SLOT_W), .DEPTH(TIMER_SLOTS)) u_prev_ram (
    .clk, .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata), .raddr(rd_addr), .rdata(pv_rdata)
  );
  ptl_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TIMER_SLOTS)) u_reload_ram (
    .clk, .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata), .raddr(rd_addr), .rdata(rl_rdata)
  );
  ptl_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TIMER_SLOTS)) u_remain_ram (
    .clk, .we(rm_we), .waddr(rm_waddr), .wdata(rm_wdata), .raddr(rd_addr), .rdata(rm_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign s_idx      = SLOT_W'(slot_r);
  assign s_in_range = (32'(slot_r) < 32'(TIMER_SLOTS));
  assign s_linked   = s_in_range && linked_r[s_idx];

  // zero period counts as one, wide periods saturate to the counter range
  assign per_nz   = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign per_wide = (32'(per_nz) > COUNT_MAX) ? COUNT_MAX : 32'(per_nz);
  assign per_sat  = COUNT_WIDTH'(per_wide);

  assign dec  = rm_rdata - COUNT_WIDTH'(1);
  assign fire = (dec == '0);
  // a firing timer needs room to hand the held expiry to the output
  assign go   = !fire || !pend_v_r || out_free;

  always_comb begin
    state_nxt     = state_r;
    linked_nxt    = linked_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    ok_nxt        = ok_r;
    t_nxt         = t_r;
    cnt_nxt       = cnt_r;
    rd_addr       = t_r;
    nx_we = 1'b0; nx_waddr = s_idx; nx_wdata = s_idx;
    pv_we = 1'b0; pv_waddr = s_idx; pv_wdata = s_idx;
    rl_we = 1'b0; rl_waddr = s_idx; rl_wdata = per_sat;
    rm_we = 1'b0; rm_waddr = s_idx; rm_wdata = per_sat;
    push       = 1'b0;
    push_kind  = KIND_STATUS;
    push_ok    = 1'b0;
    push_fired = '0;
    push_last  = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_addr = (cmd_r == CMD_TICK) ? head_r : s_idx;
        case (cmd_r)
          CMD_ADD: begin
            if (!s_in_range || s_linked) begin
              ok_nxt    = 1'b0;
              state_nxt = ST_RESP;
            end else begin
              ok_nxt = 1'b1;
              linked_nxt[s_idx] = 1'b1;
              rl_we = 1'b1;
              rm_we = 1'b1;
              nx_we = 1'b1;
              pv_we = 1'b1;
              if (count_r == '0) begin
                head_nxt  = s_idx;
                tail_nxt  = s_idx;
                count_nxt = CNT_W'(1);
                state_nxt = ST_RESP;
              end else begin
                nx_waddr  = tail_r;
                pv_waddr  = head_r;
                state_nxt = ST_ADD2;
              end
            end
          end
          CMD_REMOVE: begin
            if (!s_linked) begin
              ok_nxt    = 1'b0;
              state_nxt = ST_RESP;
            end else begin
              ok_nxt    = 1'b1;
              state_nxt = ST_RMW;
            end
          end
          CMD_CLEAR: begin
            linked_nxt = '0;
            head_nxt   = '0;
            tail_nxt   = '0;
            count_nxt  = '0;
            ok_nxt     = 1'b1;
            state_nxt  = ST_RESP;
          end
          default: begin
            t_nxt   = head_r;
            cnt_nxt = count_r;
            state_nxt = (count_r == '0) ? ST_IDLE : ST_WALK;
          end
        endcase
      end
      ST_ADD2: begin
        nx_we = 1'b1; nx_waddr = s_idx; nx_wdata = head_r;
        pv_we = 1'b1; pv_waddr = s_idx; pv_wdata = tail_r;
        tail_nxt  = s_idx;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = ST_RESP;
      end
      ST_RMW: begin
        linked_nxt[s_idx] = 1'b0;
        if (count_r <= CNT_W'(1)) begin
          count_nxt = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
        end else begin
          if (s_idx == head_r) begin
            head_nxt = nx_rdata;
          end else if (s_idx == tail_r) begin
            tail_nxt = pv_rdata;
          end
          pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = pv_rdata;
          nx_we = 1'b1; nx_waddr = pv_rdata; nx_wdata = nx_rdata;
          count_nxt = count_r - CNT_W'(1);
        end
        state_nxt = ST_RESP;
      end
      ST_WALK: begin
        if (go) begin
          rm_we    = 1'b1;
          rm_waddr = t_r;
          rm_wdata = fire ? rl_rdata : dec;
          if (fire) begin
            if (pend_v_r) begin
              push       = 1'b1;
              push_kind  = KIND_EXPIRY;
              push_fired = SLOT_FIELD_W'(pend_slot_r);
              push_last  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = t_r;
          end
          // next entry is read straight off the link memory output
          rd_addr = nx_rdata;
          t_nxt   = nx_rdata;
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_kind  = KIND_EXPIRY;
          push_fired = SLOT_FIELD_W'(pend_slot_r);
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          push      = 1'b1;
          push_ok   = ok_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = push || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      linked_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      linked_r    <= linked_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_ch.command;
      slot_r   <= in_ch.slot;
      period_r <= in_ch.period;
    end
    ok_r        <= ok_nxt;
    t_r         <= t_nxt;
    cnt_r       <= cnt_nxt;
    pend_slot_r <= pend_slot_nxt;
    if (push) begin
      out_kind_r  <= push_kind;
      out_ok_r    <= push_ok;
      out_fired_r <= push_fired;
      out_last_r  <= push_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.fired_slot = out_fired_r;
  assign out_ch.last       = out_last_r;

`ifndef ASSERT_OFF
  a_count_matches_linked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (CNT_W'($countones(linked_r)) == count_r))
    else $error("active count differs from number of linked slots");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(TIMER_SLOTS))
    else $error("active count above slot count");

  a_no_held_expiry_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("expiry still held after walk");

  a_push_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result written over an untaken result");
`endif

endmodule

/* sim/tb_top.sv */
// self-checking testbench for the periodic timer list unit
module tb_top;
  import ptl_pkg::*;

  localparam int NSLOTS      = TIMER_SLOTS_DEF;
  localparam int NUM_CMDS    = 470;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_LENGTH = 400;

  typedef struct packed {
    cmd_t                    command;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PERIOD_W-1:0]     period;
  } timer_cmd_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    ok;
    logic [SLOT_FIELD_W-1:0] fired_slot;
    logic                    last;
  } timer_result_t;

  logic clk;
  logic rst_n;

  ptl_in_if  in_ch ();
  ptl_out_if out_ch ();

  periodic_timer_list_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  timer_cmd_t    pending_cmds[$];
  timer_result_t expected_results[$];
  timer_cmd_t    cmd_on_bus;

  int cmds_sent    = 0;
  int results_seen = 0;
  int expiries     = 0;
  int errors       = 0;
  int hold_cycles  = 0;
  bit hold_done    = 0;

  // shadow of the timer list
  logic                    tl_linked [NSLOTS];
  logic [PERIOD_W-1:0]     tl_reload [NSLOTS];
  logic [PERIOD_W-1:0]     tl_left   [NSLOTS];
  logic [SLOT_FIELD_W-1:0] tl_next   [NSLOTS];
  logic [SLOT_FIELD_W-1:0] tl_prev   [NSLOTS];
  logic [SLOT_FIELD_W-1:0] tl_head;
  logic [SLOT_FIELD_W-1:0] tl_tail;
  int                      tl_active;

  task automatic predict_timer_results(input timer_cmd_t c);
    timer_result_t           r;
    timer_result_t           fired[$];
    logic [SLOT_FIELD_W-1:0] s;
    logic [SLOT_FIELD_W-1:0] t;
    logic [SLOT_FIELD_W-1:0] n;
    logic [SLOT_FIELD_W-1:0] p;
    logic [PERIOD_W-1:0]     per;
    s = c.slot;
    r = '{KIND_STATUS, 1'b0, '0, 1'b1};
    case (c.command)
      CMD_ADD: begin
        if (!tl_linked[s]) begin
          per = (c.period == '0) ? PERIOD_W'(1) : c.period;
          if (tl_active == 0) begin
            tl_head    = s;
            tl_tail    = s;
            tl_next[s] = s;
            tl_prev[s] = s;
          end else begin
            tl_next[tl_tail] = s;
            tl_prev[tl_head] = s;
            tl_prev[s]       = tl_tail;
            tl_next[s]       = tl_head;
            tl_tail          = s;
          end
          tl_active++;
          tl_linked[s] = 1'b1;
          tl_reload[s] = per;
          tl_left[s]   = per;
          r.ok         = 1'b1;
        end
        expected_results.push_back(r);
      end
      CMD_REMOVE: begin
        if (tl_linked[s]) begin
          n            = tl_next[s];
          p            = tl_prev[s];
          tl_linked[s] = 1'b0;
          r.ok         = 1'b1;
          if (tl_active <= 1) begin
            tl_active = 0;
            tl_head   = '0;
            tl_tail   = '0;
          end else begin
            if (s == tl_head) tl_head = n;
            else if (s == tl_tail) tl_tail = p;
            tl_prev[n] = p;
            tl_next[p] = n;
            tl_active--;
          end
        end
        expected_results.push_back(r);
      end
      CMD_CLEAR: begin
        foreach (tl_linked[i]) tl_linked[i] = 1'b0;
        tl_head   = '0;
        tl_tail   = '0;
        tl_active = 0;
        r.ok      = 1'b1;
        expected_results.push_back(r);
      end
      default: begin
        t = tl_head;
        for (int i = 0; i < tl_active; i++) begin
          tl_left[t] = tl_left[t] - 1'b1;
          if (tl_left[t] == '0) begin
            fired.push_back('{KIND_EXPIRY, 1'b0, t, 1'b0});
            tl_left[t] = tl_reload[t];
          end
          t = tl_next[t];
        end
        if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
        foreach (fired[i]) expected_results.push_back(fired[i]);
      end
    endcase
  endtask

  task automatic queue_cmd(input cmd_t command, input int slot, input int period);
    pending_cmds.push_back('{command, SLOT_FIELD_W'(slot), PERIOD_W'(period)});
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_TICK;
    in_ch.slot     = '0;
    in_ch.period   = '0;
    out_ch.ready   = 1'b0;
    tl_head        = '0;
    tl_tail        = '0;
    tl_active      = 0;
    foreach (tl_linked[i]) tl_linked[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #1000000;
    $display("periodic_timer_list_unit test failed");
    $finish;
  end

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_timer_results(cmd_on_bus);
        cmds_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() > 0 &&
            ((cmds_sent >= 220 && cmds_sent < 320) || $urandom_range(99) >= 8)) begin
          cmd_on_bus     = pending_cmds.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.command <= cmd_on_bus.command;
          in_ch.slot    <= cmd_on_bus.slot;
          in_ch.period  <= cmd_on_bus.period;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d ok=%0d slot=%0d last=%0d", $time,
                   out_ch.kind, out_ch.ok, out_ch.fired_slot, out_ch.last);
        end else begin
          timer_result_t e;
          e = expected_results.pop_front();
          if (e.kind == KIND_EXPIRY) expiries++;
          if (out_ch.kind !== e.kind || out_ch.ok !== e.ok ||
              out_ch.fired_slot !== e.fired_slot || out_ch.last !== e.last) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d ok=%0d slot=%0d last=%0d, got kind=%0d ok=%0d slot=%0d last=%0d",
                     $time, e.kind, e.ok, e.fired_slot, e.last,
                     out_ch.kind, out_ch.ok, out_ch.fired_slot, out_ch.last);
          end
        end
      end
      // one long back-pressure stretch so the walk stalls and input backs up
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 100) begin
        hold_done    = 1;
        hold_cycles  = HOLD_LENGTH;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= (cmds_sent >= 220 && cmds_sent < 320) || $urandom_range(99) >= 8;
      end
    end
  end

  initial begin
    int                  order[NSLOTS];
    int                  j;
    int                  tmp;
    int                  roll;
    int                  total;
    bit                  all_ones;
    // empty list, failed commands, zero and full-scale periods
    queue_cmd(CMD_TICK,   0, 0);
    queue_cmd(CMD_REMOVE, 5, 0);
    queue_cmd(CMD_ADD,    0, 0);
    queue_cmd(CMD_ADD,    0, 3);
    queue_cmd(CMD_ADD,    15, 65535);
    queue_cmd(CMD_TICK,   0, 0);
    queue_cmd(CMD_REMOVE, 0, 0);
    queue_cmd(CMD_REMOVE, 15, 0);
    queue_cmd(CMD_TICK,   0, 0);
    queue_cmd(CMD_CLEAR,  0, 0);
    // several timers, removal at middle, tail and head
    queue_cmd(CMD_ADD,    3, 2);
    queue_cmd(CMD_ADD,    9, 1);
    queue_cmd(CMD_ADD,    12, 2);
    queue_cmd(CMD_ADD,    6, 4);
    queue_cmd(CMD_TICK,   0, 0);
    queue_cmd(CMD_TICK,   0, 0);
    queue_cmd(CMD_REMOVE, 12, 0);
    queue_cmd(CMD_REMOVE, 6, 0);
    queue_cmd(CMD_REMOVE, 3, 0);
    queue_cmd(CMD_ADD,    3, 1);
    queue_cmd(CMD_TICK,   0, 0);
    queue_cmd(CMD_CLEAR,  0, 0);
    queue_cmd(CMD_TICK,   0, 0);
    queue_cmd(CMD_ADD,    10, 16'hAAAA);
    queue_cmd(CMD_ADD,    5, 16'h5555);

    while (pending_cmds.size() < NUM_CMDS) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        // fill every slot in shuffled order, then tick
        foreach (order[i]) order[i] = i;
        for (int i = NSLOTS - 1; i > 0; i--) begin
          j        = $urandom_range(i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        all_ones = $urandom_range(1);
        queue_cmd(CMD_CLEAR, 0, 0);
        foreach (order[i]) queue_cmd(CMD_ADD, order[i], all_ones ? 1 : $urandom_range(1, 3));
        repeat (3) queue_cmd(CMD_TICK, 0, 0);
      end else if (roll < 42) begin
        roll = $urandom_range(99);
        queue_cmd(CMD_ADD, $urandom_range(NSLOTS - 1),
                  roll < 10 ? 0 : roll < 75 ? $urandom_range(1, 6) : $urandom_range(65535));
      end else if (roll < 60) begin
        queue_cmd(CMD_REMOVE, $urandom_range(NSLOTS - 1), $urandom_range(65535));
      end else if (roll < 96) begin
        queue_cmd(CMD_TICK, $urandom_range(NSLOTS - 1), $urandom_range(65535));
      end else begin
        queue_cmd(CMD_CLEAR, $urandom_range(NSLOTS - 1), $urandom_range(65535));
      end
    end
    total = pending_cmds.size();

    @(posedge clk);
    while (cmds_sent < total || expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("applied %0d add/remove/tick/clear commands, checked %0d results (%0d expiries)",
             cmds_sent, results_seen, expiries);
    $display("included full-list expiries and one long output stall; %0d errors", errors);
    if (errors == 0) begin
      $display("periodic_timer_list_unit test passed");
    end else begin
      $display("periodic_timer_list_unit test failed");
    end
    $finish;
  end

endmodule
